/* design/khmt_pkg.sv */
// package for the killer move and history table block
// holds operation codes, controller states, command/status structs and fixed sizes
// no dependencies
`timescale 1ns / 1ps

package khmt_pkg;

  typedef enum logic [2:0] {
    FN_PUSH_KILLER  = 3'd0,
    FN_QUERY_KILLER = 3'd1,
    FN_ADD_HISTORY  = 3'd2,
    FN_READ_HISTORY = 3'd3,
    FN_CLEAR        = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  localparam int FUNC_BITS    = 3;
  localparam int MOVE_IN_BITS = 16;
  localparam int PLY_IN_BITS  = 6;
  localparam int SQ_BITS      = 6;
  localparam int DEPTH_BITS   = 6;
  localparam int INC_BITS     = 2 * DEPTH_BITS;
  localparam int SCORE_BITS   = 32;
  localparam int HIST_AW      = 1 + 2 * SQ_BITS;
  localparam int HIST_DEPTH   = 2 * 64 * 64;

  typedef struct packed {
    logic load;
    logic exec;
    logic clr_step;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_op;
    logic clr_last;
  } dp_status_t;

endpackage

/* design/killer_and_history_move_table_unit.sv */
// killer move and history counter tables for move ordering
// each item reads its table row at accept and writes it back in the execute state,
// which sets result_valid and waits while a held result is not taken; no new item
// is accepted before that write. reset and the clear operation sweep all 8192 history
// entries with item_ready low; killer rows are emptied at once through per-row valid bits
`timescale 1ns / 1ps

module killer_and_history_move_table_unit import khmt_pkg::*; #(
  parameter int MAX_PLY         = 64,
  parameter int KILLERS_PER_PLY = 4,
  parameter int MOVE_BITS       = 16,
  parameter int COUNT_BITS      = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_ready,
  input  logic [FUNC_BITS-1:0]    func,
  input  logic [MOVE_IN_BITS-1:0] move_code,
  input  logic [PLY_IN_BITS-1:0]  ply,
  input  logic                    side,
  input  logic [SQ_BITS-1:0]      from_square,
  input  logic [SQ_BITS-1:0]      to_square,
  input  logic [DEPTH_BITS-1:0]   depth,
  output logic                    result_valid,
  input  logic                    result_ready,
  output logic                    is_killer,
  output logic [SCORE_BITS-1:0]   history_score
);

  dp_cmd_t    cmd;
  dp_status_t status;

  khmt_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd),
    .status       (status)
  );

  khmt_dp #(
    .MAX_PLY         (MAX_PLY),
    .KILLERS_PER_PLY (KILLERS_PER_PLY),
    .MOVE_BITS       (MOVE_BITS),
    .COUNT_BITS      (COUNT_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .func          (func),
    .move_code     (move_code),
    .ply           (ply),
    .side          (side),
    .from_square   (from_square),
    .to_square     (to_square),
    .depth         (depth),
    .is_killer     (is_killer),
    .history_score (history_score)
  );

endmodule

/* design/khmt_ctrl.sv */
// controller state machine for the killer move and history table block
// sequences accept, execute and the history clearing sweep; owns result valid
// depends on khmt_pkg
`timescale 1ns / 1ps

module khmt_ctrl import khmt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  output logic       result_valid,
  input  logic       result_ready,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  state_t state;
  state_t state_next;
  logic   result_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  always_comb begin
    state_next        = state;
    result_valid_next = result_valid && !result_ready;
    item_ready        = 1'b0;
    cmd               = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!result_valid || result_ready) begin
          cmd.exec          = 1'b1;
          result_valid_next = 1'b1;
          state_next        = status.clear_op ? ST_CLEAR : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

/* design/khmt_dp.sv */
// datapath for the killer move and history table block
// killer row memory with per-row valid bits, history counter memory, result registers
// depends on khmt_pkg
`timescale 1ns / 1ps

module khmt_dp import khmt_pkg::*; #(
  parameter int MAX_PLY         = 64,
  parameter int KILLERS_PER_PLY = 4,
  parameter int MOVE_BITS       = 16,
  parameter int COUNT_BITS      = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dp_cmd_t                 cmd,
  output dp_status_t              status,
  input  logic [FUNC_BITS-1:0]    func,
  input  logic [MOVE_IN_BITS-1:0] move_code,
  input  logic [PLY_IN_BITS-1:0]  ply,
  input  logic                    side,
  input  logic [SQ_BITS-1:0]      from_square,
  input  logic [SQ_BITS-1:0]      to_square,
  input  logic [DEPTH_BITS-1:0]   depth,
  output logic                    is_killer,
  output logic [SCORE_BITS-1:0]   history_score
);

  localparam int KROW_AW = $clog2(MAX_PLY);
  localparam int KROW_W  = KILLERS_PER_PLY * MOVE_BITS;
  localparam int ROW_X_W = (KROW_AW > PLY_IN_BITS) ? KROW_AW : PLY_IN_BITS;
  localparam int MV_X_W  = (MOVE_BITS > MOVE_IN_BITS) ? MOVE_BITS : MOVE_IN_BITS;
  localparam int SUM_W   = COUNT_BITS + 1;
  localparam int SCX_W   = (COUNT_BITS > SCORE_BITS) ? COUNT_BITS : SCORE_BITS;

  logic [KROW_W-1:0]     kmem [MAX_PLY];
  logic [MAX_PLY-1:0]    kvalid;
  logic [COUNT_BITS-1:0] hmem [HIST_DEPTH];

  // input side decode
  logic [ROW_X_W-1:0] ply_x;
  logic [KROW_AW-1:0] row_in;
  logic [MV_X_W-1:0]  mv_x;
  logic [HIST_AW-1:0] haddr_in;
  logic               in_range_in;

  assign ply_x       = ROW_X_W'(ply);
  assign row_in      = ply_x[KROW_AW-1:0];
  assign mv_x        = MV_X_W'(move_code);
  assign haddr_in    = {side, from_square, to_square};
  assign in_range_in = (32'(ply) < 32'(MAX_PLY));

  // latched transaction
  func_t                 func_q;
  logic [MOVE_BITS-1:0]  mv_q;
  logic [KROW_AW-1:0]    row_q;
  logic                  in_range_q;
  logic [HIST_AW-1:0]    haddr_q;
  logic [INC_BITS-1:0]   inc_q;
  logic [KROW_W-1:0]     krow_q;
  logic                  kvalid_q;
  logic [COUNT_BITS-1:0] hist_q;
  logic [HIST_AW-1:0]    clr_cnt;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q     <= func_t'(func);
      mv_q       <= mv_x[MOVE_BITS-1:0];
      row_q      <= row_in;
      in_range_q <= in_range_in;
      haddr_q    <= haddr_in;
      inc_q      <= INC_BITS'(depth) * INC_BITS'(depth);
      krow_q     <= kmem[row_in];
      kvalid_q   <= kvalid[row_in];
      hist_q     <= hmem[haddr_in];
    end
  end

  // killer row evaluation
  logic [KROW_W-1:0] row_cur;
  logic [KROW_W-1:0] row_new;
  logic              match;

  always_comb begin
    row_cur = kvalid_q ? krow_q : '0;
    match   = 1'b0;
    for (int k = 0; k < KILLERS_PER_PLY; k++) begin
      if (row_cur[k*MOVE_BITS +: MOVE_BITS] == mv_q) begin
        match = 1'b1;
      end
    end
    row_new = (row_cur << MOVE_BITS) | KROW_W'(mv_q);
  end

  logic do_push;
  logic do_add;

  assign do_push = cmd.exec && (func_q == FN_PUSH_KILLER) && in_range_q && !match;
  assign do_add  = cmd.exec && (func_q == FN_ADD_HISTORY);

  always_ff @(posedge clk) begin
    if (do_push) begin
      kmem[row_q] <= row_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kvalid <= '0;
    end else if (cmd.exec && (func_q == FN_CLEAR)) begin
      kvalid <= '0;
    end else if (do_push) begin
      kvalid[row_q] <= 1'b1;
    end
  end

  // history saturating add and read clamp
  logic [SUM_W-1:0]      sum;
  logic [COUNT_BITS-1:0] hist_new;
  logic [SCX_W-1:0]      hist_x;
  logic [SCORE_BITS-1:0] score_sat;

  assign sum       = {1'b0, hist_q} + SUM_W'(inc_q);
  assign hist_new  = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
  assign hist_x    = SCX_W'(hist_q);
  assign score_sat = (hist_x > SCX_W'({SCORE_BITS{1'b1}})) ? '1 : hist_x[SCORE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      hmem[clr_cnt] <= '0;
    end else if (do_add) begin
      hmem[haddr_q] <= hist_new;
    end
  end

  // clearing sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.exec) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign status.clr_last = (clr_cnt == HIST_AW'(HIST_DEPTH - 1));
  assign status.clear_op = (func_q == FN_CLEAR);

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      is_killer     <= (func_q == FN_QUERY_KILLER) && in_range_q && match;
      history_score <= (func_q == FN_READ_HISTORY) ? score_sat : '0;
    end
  end

endmodule

/* design/khmt_checker.sv */
// port-level checker for the killer move and history table block
// bound to killer_and_history_move_table_unit; depends on nothing else
`timescale 1ns / 1ps

module khmt_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic        is_killer,
  input logic [31:0] history_score
);

  // held result stays put
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(is_killer) && $stable(history_score))
    else $error("result changed while stalled");

  // one transaction at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item accepted while previous still executing");

  // only one field carries a value
  a_exclusive_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(is_killer && (history_score != 32'd0)))
    else $error("both result fields nonzero");

  // reset starts the clearing sweep
  a_reset_sweep: assert property (@(posedge clk)
    rst |=> !item_ready && !result_valid)
    else $error("block not in clear sweep after reset");

endmodule

bind killer_and_history_move_table_unit khmt_checker u_khmt_checker (
  .clk           (clk),
  .rst           (rst),
  .item_valid    (item_valid),
  .item_ready    (item_ready),
  .result_valid  (result_valid),
  .result_ready  (result_ready),
  .is_killer     (is_killer),
  .history_score (history_score)
);
